// File: design/nkt_pkg.sv
package nkt_pkg;

  localparam int CAPACITY    = 16;
  localparam int NAME_CHUNKS = 4;
  localparam int TYPE_CHUNKS = 3;

  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int PART_W  = 2;
  localparam int QTY_W   = 16;
  localparam int CHUNK_W = 64;
  localparam int KEY_W   = NAME_CHUNKS * CHUNK_W;
  localparam int TYP_W   = TYPE_CHUNKS * CHUNK_W;
  localparam int TADDR_W = $clog2(CAPACITY * TYPE_CHUNKS);

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NAME_NONE = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_TYPE_NONE = 3'd4;
  localparam logic [2:0] ST_QTY_ZERO  = 3'd5;
  localparam logic [2:0] ST_TBL_EMPTY = 3'd6;
  localparam logic [2:0] ST_NOT_FOUND = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_move;
  } lane_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b - CH_UPPER_A + CH_LOWER_A;
    end
    return r;
  endfunction

  // Bytes after the first zero byte are forced to zero; letters are folded.
  function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] v);
    logic [KEY_W-1:0] r;
    logic             ended;
    logic [7:0]       b;
    ended = 1'b0;
    r     = '0;
    for (int k = 0; k < NAME_CHUNKS * 8; k++) begin
      b = v[k*8 +: 8];
      if (ended) begin
        b = 8'd0;
      end else if (b == 8'd0) begin
        ended = 1'b1;
      end
      r[k*8 +: 8] = fold_byte(b);
    end
    return r;
  endfunction

  function automatic logic [TYP_W-1:0] clean_type(input logic [TYP_W-1:0] v);
    logic [TYP_W-1:0] r;
    logic             ended;
    logic [7:0]       b;
    ended = 1'b0;
    r     = '0;
    for (int k = 0; k < TYPE_CHUNKS * 8; k++) begin
      b = v[k*8 +: 8];
      if (ended) begin
        b = 8'd0;
      end else if (b == 8'd0) begin
        ended = 1'b1;
      end
      r[k*8 +: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [TADDR_W-1:0] typ_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [PART_W-1:0] part);
    return TADDR_W'(slot) * TADDR_W'(TYPE_CHUNKS) + TADDR_W'(part);
  endfunction

endpackage

// File: design/nkt_lane.sv
module nkt_lane
  import nkt_pkg::*;
(
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic [CHUNK_W-1:0] key_chunk,
  output logic               match
);

  logic [CHUNK_W-1:0] mem [CAPACITY];
  logic [CHUNK_W-1:0] rd_data_r;

  // A move writes back the slice this lane read in the cycle before.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_move ? rd_data_r : key_chunk;
    end
    rd_data_r <= mem[ctl.rd_addr];
  end

  assign match = (rd_data_r == key_chunk);

endmodule

// File: design/nkt_merge.sv
module nkt_merge
  import nkt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr,
  input  logic                   eval,
  input  logic [NAME_CHUNKS-1:0] lane_match,
  input  logic [SLOT_W-1:0]      scan_idx,
  output logic                   hit,
  output logic                   found_r,
  output logic [SLOT_W-1:0]      found_slot_r
);

  assign hit = &lane_match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clr) begin
      found_r <= 1'b0;
    end else if (eval && hit && !found_r) begin
      found_r      <= 1'b1;
      found_slot_r <= scan_idx;
    end
  end

endmodule

// File: design/name_keyed_table_insert_remove_search_unit.sv
// A command runs a name scan over the table entries, then writes, moves or reads the
// entry one type chunk at a time and emits its results.
// One command at a time: input items are taken only while the unit is idle.
// The scan reads one entry at a time across the name lanes.
// Reset clears the entry count and key buffers; stores hold garbage until written.
module name_keyed_table_insert_remove_search_unit
  import nkt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[1:0], chunk_index[3:2], name_chunk[67:4], type_chunk[131:68], quantity[147:132]
  input  logic [151:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], slot[6:3], found_quantity[22:7], used_count[27:23],
  // found_type_chunk[91:28], part_index[93:92]
  output logic [95:0]  out_tdata,
  output logic         out_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAN, S_RD, S_CMP, S_DEC, S_INS_WR, S_MV_RD, S_MV_WR,
    S_SR_RD, S_SR_LD, S_EMIT
  } state_t;

  state_t            state_r;
  logic [1:0]        op_r;
  logic [QTY_W-1:0]  qty_r;
  logic [KEY_W-1:0]  key_buf_r;
  logic [TYP_W-1:0]  type_buf_r;
  logic [CNT_W-1:0]  count_r;
  logic [SLOT_W-1:0] scan_r;
  logic [PART_W-1:0] part_r;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [QTY_W-1:0]   out_qty_r;
  logic [CNT_W-1:0]   out_used_r;
  logic [CHUNK_W-1:0] out_type_r;
  logic [PART_W-1:0]  out_part_r;
  logic               out_last_r;

  logic [CHUNK_W-1:0] typ_mem [CAPACITY * TYPE_CHUNKS];
  logic [QTY_W-1:0]   qty_mem [CAPACITY];
  logic [CHUNK_W-1:0] typ_rd_r;
  logic [QTY_W-1:0]   qty_rd_r;

  logic [1:0]          in_op;
  logic [1:0]          in_ci;
  logic [KEY_W-1:0]    key_clean;
  logic [TYP_W-1:0]    type_clean;
  logic [SLOT_W-1:0]   last_slot;
  logic [SLOT_W-1:0]   cnt_slot;
  lane_ctl_t           lane_ctl;
  logic [NAME_CHUNKS-1:0] lane_match;
  logic                hit;
  logic                found_r;
  logic [SLOT_W-1:0]   found_slot_r;
  logic                merge_clr;
  logic                merge_eval;
  logic [TADDR_W-1:0]  typ_raddr;
  logic [SLOT_W-1:0]   qty_raddr;
  logic [CHUNK_W-1:0]  cur_type_chunk;

  assign in_op      = in_tdata[1:0];
  assign in_ci      = in_tdata[3:2];
  assign key_clean  = clean_key(key_buf_r);
  assign type_clean = clean_type(type_buf_r);
  assign last_slot  = SLOT_W'(count_r - CNT_W'(1));
  assign cnt_slot   = SLOT_W'(count_r);
  assign cur_type_chunk = type_buf_r[part_r*CHUNK_W +: CHUNK_W];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_part_r, out_type_r, out_used_r, out_qty_r, out_slot_r,
                       out_status_r};

  always_comb begin
    lane_ctl.rd_addr = scan_r;
    lane_ctl.wr_en   = 1'b0;
    lane_ctl.wr_addr = cnt_slot;
    lane_ctl.wr_move = 1'b0;
    typ_raddr = typ_addr(found_slot_r, part_r);
    qty_raddr = found_slot_r;
    case (state_r)
      S_INS_WR: begin
        lane_ctl.wr_en = (part_r == '0);
      end
      S_MV_RD: begin
        lane_ctl.rd_addr = last_slot;
        typ_raddr = typ_addr(last_slot, part_r);
        qty_raddr = last_slot;
      end
      S_MV_WR: begin
        lane_ctl.rd_addr = last_slot;
        lane_ctl.wr_en   = (part_r == '0);
        lane_ctl.wr_addr = found_slot_r;
        lane_ctl.wr_move = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign merge_clr  = (state_r == S_CLEAN);
  assign merge_eval = (state_r == S_CMP);

  for (genvar g = 0; g < NAME_CHUNKS; g++) begin : g_lane
    nkt_lane u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .key_chunk (key_buf_r[g*CHUNK_W +: CHUNK_W]),
      .match     (lane_match[g])
    );
  end

  nkt_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .clr          (merge_clr),
    .eval         (merge_eval),
    .lane_match   (lane_match),
    .scan_idx     (scan_r),
    .hit          (hit),
    .found_r      (found_r),
    .found_slot_r (found_slot_r)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_INS_WR) begin
      typ_mem[typ_addr(cnt_slot, part_r)] <= cur_type_chunk;
      if (part_r == '0) begin
        qty_mem[cnt_slot] <= qty_r;
      end
    end else if (state_r == S_MV_WR) begin
      typ_mem[typ_addr(found_slot_r, part_r)] <= typ_rd_r;
      if (part_r == '0) begin
        qty_mem[found_slot_r] <= qty_rd_r;
      end
    end
    typ_rd_r <= typ_mem[typ_raddr];
    qty_rd_r <= qty_mem[qty_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      key_buf_r   <= '0;
      type_buf_r  <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      part_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            if (32'(in_ci) < NAME_CHUNKS) begin
              key_buf_r[in_ci*CHUNK_W +: CHUNK_W] <= in_tdata[67:4];
            end
            if (32'(in_ci) < TYPE_CHUNKS) begin
              type_buf_r[in_ci*CHUNK_W +: CHUNK_W] <= in_tdata[131:68];
            end
            if (in_tlast) begin
              op_r    <= in_op;
              qty_r   <= in_tdata[147:132];
              state_r <= S_CLEAN;
            end
          end
        end
        S_CLEAN: begin
          key_buf_r  <= key_clean;
          type_buf_r <= type_clean;
          scan_r     <= '0;
          part_r     <= '0;
          out_slot_r <= '0;
          out_qty_r  <= '0;
          out_used_r <= count_r;
          out_type_r <= '0;
          out_part_r <= '0;
          out_last_r <= 1'b1;
          case (op_r)
            OP_INSERT: begin
              if (32'(count_r) >= CAPACITY) begin
                out_status_r <= ST_FULL;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else if (key_clean[7:0] == 8'd0) begin
                out_status_r <= ST_NAME_NONE;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else begin
                state_r <= (count_r == '0) ? S_DEC : S_RD;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                out_status_r <= ST_TBL_EMPTY;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else begin
                state_r <= S_RD;
              end
            end
            OP_SEARCH: begin
              state_r <= (count_r == '0) ? S_DEC : S_RD;
            end
            default: begin
              key_buf_r  <= '0;
              type_buf_r <= '0;
              state_r    <= S_IDLE;
            end
          endcase
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (hit || (CNT_W'(scan_r) + CNT_W'(1) >= count_r)) begin
            state_r <= S_DEC;
          end else begin
            scan_r  <= scan_r + SLOT_W'(1);
            state_r <= S_RD;
          end
        end
        S_DEC: begin
          case (op_r)
            OP_INSERT: begin
              if (found_r) begin
                out_status_r <= ST_DUP;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else if (type_buf_r[7:0] == 8'd0) begin
                out_status_r <= ST_TYPE_NONE;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else if (qty_r == '0) begin
                out_status_r <= ST_QTY_ZERO;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else begin
                state_r <= S_INS_WR;
              end
            end
            OP_REMOVE: begin
              if (!found_r) begin
                out_status_r <= ST_NOT_FOUND;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else begin
                state_r <= S_MV_RD;
              end
            end
            default: begin
              if (!found_r) begin
                out_status_r <= ST_NOT_FOUND;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end else begin
                state_r <= S_SR_RD;
              end
            end
          endcase
        end
        S_INS_WR: begin
          if (32'(part_r) + 1 >= TYPE_CHUNKS) begin
            part_r       <= '0;
            count_r      <= count_r + CNT_W'(1);
            out_status_r <= ST_OK;
            out_slot_r   <= cnt_slot;
            out_used_r   <= count_r + CNT_W'(1);
            out_valid_r  <= 1'b1;
            state_r      <= S_EMIT;
          end else begin
            part_r <= part_r + PART_W'(1);
          end
        end
        S_MV_RD: begin
          state_r <= S_MV_WR;
        end
        S_MV_WR: begin
          if (32'(part_r) + 1 >= TYPE_CHUNKS) begin
            part_r       <= '0;
            count_r      <= count_r - CNT_W'(1);
            out_status_r <= ST_OK;
            out_slot_r   <= found_slot_r;
            out_used_r   <= count_r - CNT_W'(1);
            out_valid_r  <= 1'b1;
            state_r      <= S_EMIT;
          end else begin
            part_r  <= part_r + PART_W'(1);
            state_r <= S_MV_RD;
          end
        end
        S_SR_RD: begin
          state_r <= S_SR_LD;
        end
        S_SR_LD: begin
          out_status_r <= ST_OK;
          out_slot_r   <= found_slot_r;
          out_qty_r    <= qty_rd_r;
          out_type_r   <= typ_rd_r;
          out_part_r   <= part_r;
          out_last_r   <= (32'(part_r) + 1 >= TYPE_CHUNKS);
          out_valid_r  <= 1'b1;
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (op_r == OP_SEARCH && found_r && !out_last_r) begin
              part_r  <= part_r + PART_W'(1);
              state_r <= S_SR_RD;
            end else begin
              key_buf_r  <= '0;
              type_buf_r <= '0;
              state_r    <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !out_valid_r)
    else $error("result pending while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1) ||
              count_r + CNT_W'(1) == $past(count_r)))
    else $error("entry count jumped");

  a_count_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r) && $past(rst_n)) |-> (out_valid_r && out_status_r == ST_OK))
    else $error("entry count changed without a success result");

endmodule
